// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/bmre_pkg.sv =====
`timescale 1ns / 1ps

package bmre_pkg;

  localparam int unsigned VOLT_W    = 8;
  localparam int unsigned STAT_W    = 8;
  localparam int unsigned PWR_W     = 16;
  localparam int unsigned CAP_W     = 16;
  localparam int unsigned EXTRA_W   = 10;
  localparam int unsigned TOTAL_W   = 17;
  localparam int unsigned RUNTIME_W = 20;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned WINDOW_DEPTH_DEF    = 10;
  localparam int unsigned ESTIMATE_PERIOD_DEF = 20;

  localparam logic [VOLT_W-1:0]  EMPTY_LEVEL_RST = 8'd100;
  localparam logic [VOLT_W-1:0]  LOW_LEVEL_RST   = 8'd110;
  localparam logic [CAP_W-1:0]   CAPACITY_RST    = 16'd1000;
  localparam logic [EXTRA_W-1:0] EXTRA_POWER_RST = 10'd40;

  localparam logic [RUNTIME_W-1:0] RUNTIME_MAX   = {RUNTIME_W{1'b1}};
  localparam logic [RUNTIME_W-1:0] UPDATE_MARGIN = 20'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMPTY_LEVEL = 2'd0,
    CFG_LOW_LEVEL   = 2'd1,
    CFG_CAPACITY    = 2'd2,
    CFG_EXTRA_POWER = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    HEALTH_OK     = 3'd0,
    HEALTH_LOW    = 3'd1,
    HEALTH_EMPTY  = 3'd2,
    HEALTH_PC_OFF = 3'd3,
    HEALTH_STALE  = 3'd4
  } health_e;

  typedef enum logic [2:0] {
    CLASS_CONST_CURRENT = 3'd0,
    CLASS_CONST_VOLTAGE = 3'd1,
    CLASS_FULL          = 3'd2,
    CLASS_ON_BATTERY    = 3'd3,
    CLASS_UNKNOWN       = 3'd4
  } charge_class_e;

  typedef struct packed {
    logic              link_ok;
    logic [VOLT_W-1:0] voltage_level;
    logic [STAT_W-1:0] status_byte;
    logic [PWR_W-1:0]  board_power_dw;
  } in_req_t;

  typedef struct packed {
    health_e              health;
    logic [2:0]           chg_mode;
    charge_class_e        charge_class;
    logic                 ext_pwr;
    logic                 pc_on;
    logic                 brd_pwr;
    logic                 runtime_valid;
    logic [RUNTIME_W-1:0] runtime_tenth_min;
    logic [TOTAL_W-1:0]   total_power_dw;
  } out_res_t;

  function automatic charge_class_e decode_class(input logic [2:0] mode);
    charge_class_e cls;
    case (mode)
      3'd1:    cls = CLASS_CONST_CURRENT;
      3'd2:    cls = CLASS_CONST_VOLTAGE;
      3'd3:    cls = CLASS_FULL;
      3'd4:    cls = CLASS_ON_BATTERY;
      default: cls = CLASS_UNKNOWN;
    endcase
    return cls;
  endfunction

endpackage

// ===== sv/bmre_window.sv =====
`timescale 1ns / 1ps

module bmre_window import bmre_pkg::*; #(
  parameter int unsigned DEPTH = WINDOW_DEPTH_DEF,
  parameter int unsigned FILL_W = $clog2(DEPTH + 1),
  parameter int unsigned SUM_W = VOLT_W + FILL_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [VOLT_W-1:0] volt_i,
  output logic [FILL_W-1:0] fill_o,
  output logic [SUM_W-1:0]  sum_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VOLT_W-1:0] win_q [DEPTH];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              full;

  assign full = (fill_q == FILL_W'(DEPTH));

  always_comb begin
    fill_d = fill_q;
    ptr_d  = ptr_q;
    sum_d  = sum_q;
    if (push_i) begin
      // Once the window is full the oldest sample sits at the write pointer.
      if (full) begin
        sum_d = sum_q - SUM_W'(win_q[ptr_q]) + SUM_W'(volt_i);
      end else begin
        fill_d = fill_q + FILL_W'(1);
        sum_d  = sum_q + SUM_W'(volt_i);
      end
      ptr_d = (ptr_q == PTR_W'(DEPTH - 1)) ? '0 : ptr_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ptr_q  <= '0;
      sum_q  <= '0;
    end else begin
      fill_q <= fill_d;
      ptr_q  <= ptr_d;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      win_q[ptr_q] <= volt_i;
    end
  end

  assign fill_o = fill_q;
  assign sum_o  = sum_q;

endmodule

// ===== sv/bmre_div.sv =====
`timescale 1ns / 1ps

module bmre_div import bmre_pkg::*; #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 22
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_W-1:0]     num_i,
  input  logic [DEN_W-1:0]     den_i,
  output logic                 done_o,
  output logic [RUNTIME_W-1:0] quot_o
);

  // One quotient bit beyond the result width tells saturation apart.
  localparam int unsigned QW    = RUNTIME_W + 1;
  localparam int unsigned HI_W  = NUM_W - QW;
  localparam int unsigned CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [QW-1:0]    lo_q;
  logic             ovf_q;
  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;

  logic [HI_W-1:0]  num_hi;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign num_hi = num_i[NUM_W-1:QW];
  assign trial  = {rem_q, lo_q[QW-1]};
  assign fits   = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QW);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // If the upper part already reaches the divisor the quotient cannot fit.
      ovf_q <= (CMP_W'(num_hi) >= CMP_W'(den_i));
      rem_q <= DEN_W'(num_hi);
      den_q <= den_i;
      lo_q  <= num_i[QW-1:0];
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      lo_q  <= {lo_q[QW-2:0], fits};
    end
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = (ovf_q || lo_q[QW-1]) ? RUNTIME_MAX : lo_q[RUNTIME_W-1:0];

endmodule

// ===== sv/battery_monitor_runtime_estimator.sv =====
`timescale 1ns / 1ps
// A stale or ordinary poll goes from the request straight to the output state; a poll that
// runs the runtime estimate passes through the multiply and prepare states and, when the
// divisor is nonzero, the bit-serial divider, which produces one quotient bit per cycle,
// and the update state. One poll is taken at a time; the output register frees the input.
// Reset: configuration returns to its defaults, the voltage window empties, and the tick
// counter, runtime and power stores clear to zero.

module battery_monitor_runtime_estimator import bmre_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH    = WINDOW_DEPTH_DEF,
  parameter int unsigned ESTIMATE_PERIOD = ESTIMATE_PERIOD_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_req_t               in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_res_t              out_res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = VOLT_W + FILL_W;
  localparam int unsigned PROD_W = CAP_W + SUM_W;
  localparam int unsigned NUM_W  = PROD_W + 3;
  localparam int unsigned DEN_W  = FILL_W + TOTAL_W;
  localparam int unsigned TICK_W = (ESTIMATE_PERIOD > 1) ? $clog2(ESTIMATE_PERIOD) : 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_PREP = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [VOLT_W-1:0]  empty_q, low_q;
  logic [CAP_W-1:0]   cap_q;
  logic [EXTRA_W-1:0] extra_q;

  logic [TICK_W-1:0]    tick_q;
  logic [RUNTIME_W-1:0] runtime_q;
  logic [TOTAL_W-1:0]   power_q;
  logic                 stale_q;
  out_res_t             res_q;
  logic [PROD_W-1:0]    prod_q;

  logic                 out_valid_q;
  out_res_t             out_q;

  logic                 accept;
  logic                 push;
  logic                 fire;
  logic [FILL_W-1:0]    fill;
  logic [SUM_W-1:0]     sum;
  logic [TOTAL_W-1:0]   total;
  logic [NUM_W-1:0]     num;
  logic [DEN_W-1:0]     den;
  logic                 div_start;
  logic                 div_done;
  logic [RUNTIME_W-1:0] quot;
  logic [RUNTIME_W-1:0] diff;
  logic                 out_free;
  health_e              health;
  logic [2:0]           mode;
  out_res_t             res_fin;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign push       = accept && in_req_i.link_ok;
  assign fire       = (tick_q == TICK_W'(ESTIMATE_PERIOD - 1));
  assign total      = TOTAL_W'(in_req_i.board_power_dw) + TOTAL_W'(extra_q);
  assign num        = (NUM_W'(prod_q) << 2) + (NUM_W'(prod_q) << 1);
  assign den        = DEN_W'(fill) * DEN_W'(power_q);
  assign div_start  = (state_q == ST_PREP) && (den != '0);
  assign diff       = (quot > runtime_q) ? quot - runtime_q : runtime_q - quot;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign mode       = in_req_i.status_byte[5:3];

  always_comb begin
    if (!in_req_i.status_byte[1]) begin
      health = HEALTH_PC_OFF;
    end else if (in_req_i.voltage_level < empty_q) begin
      health = HEALTH_EMPTY;
    end else if (in_req_i.voltage_level <= low_q) begin
      health = HEALTH_LOW;
    end else begin
      health = HEALTH_OK;
    end
  end

  bmre_window #(
    .DEPTH  (WINDOW_DEPTH),
    .FILL_W (FILL_W),
    .SUM_W  (SUM_W)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .volt_i (in_req_i.voltage_level),
    .fill_o (fill),
    .sum_o  (sum)
  );

  bmre_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_i.link_ok && fire && (in_req_i.board_power_dw != '0)) begin
            state_d = ST_MUL;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_MUL:  state_d = ST_PREP;
      ST_PREP: state_d = (den != '0) ? ST_DIV : ST_OUT;
      ST_DIV:  state_d = div_done ? ST_UPD : ST_DIV;
      ST_UPD:  state_d = ST_OUT;
      ST_OUT:  state_d = out_free ? ST_IDLE : ST_OUT;
      default: state_d = ST_IDLE;
    endcase
  end

  // A stale poll reports nothing but its health.
  always_comb begin
    res_fin                   = res_q;
    res_fin.runtime_valid     = (runtime_q != '0);
    res_fin.runtime_tenth_min = runtime_q;
    res_fin.total_power_dw    = power_q;
    if (stale_q) begin
      res_fin        = '0;
      res_fin.health = HEALTH_STALE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      empty_q     <= EMPTY_LEVEL_RST;
      low_q       <= LOW_LEVEL_RST;
      cap_q       <= CAPACITY_RST;
      extra_q     <= EXTRA_POWER_RST;
      tick_q      <= '0;
      runtime_q   <= '0;
      power_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_EMPTY_LEVEL: empty_q <= cfg_data_i[VOLT_W-1:0];
          CFG_LOW_LEVEL:   low_q   <= cfg_data_i[VOLT_W-1:0];
          CFG_CAPACITY:    cap_q   <= cfg_data_i[CAP_W-1:0];
          CFG_EXTRA_POWER: extra_q <= cfg_data_i[EXTRA_W-1:0];
          default: ;
        endcase
      end
      if (push) begin
        tick_q <= fire ? '0 : tick_q + TICK_W'(1);
        if (fire && (in_req_i.board_power_dw != '0)) begin
          power_q <= total;
        end
      end
      // A new estimate only replaces the stored one when it moved by more than the margin.
      if ((state_q == ST_UPD) && (diff > UPDATE_MARGIN)) begin
        runtime_q <= quot;
      end
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stale_q                 <= !in_req_i.link_ok;
      res_q.health            <= in_req_i.link_ok ? health : HEALTH_STALE;
      res_q.chg_mode          <= mode;
      res_q.charge_class      <= decode_class(mode);
      res_q.ext_pwr           <= in_req_i.status_byte[2];
      res_q.pc_on             <= in_req_i.status_byte[1];
      res_q.brd_pwr           <= in_req_i.status_byte[0];
      res_q.runtime_valid     <= 1'b0;
      res_q.runtime_tenth_min <= '0;
      res_q.total_power_dw    <= '0;
    end
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(cap_q) * PROD_W'(sum);
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_q <= res_fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// ===== sv/bmre_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bmre_checker import bmre_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_res_t out_res_o
);

  logic stale_seen;
  logic stale_clean;
  logic flag_ok;

  assign stale_seen  = out_valid_o && (out_res_o.health == HEALTH_STALE);
  assign stale_clean = (out_res_o.runtime_tenth_min == '0) &&
                       (out_res_o.total_power_dw == '0) && !out_res_o.runtime_valid;
  assign flag_ok     = (out_res_o.runtime_valid == (out_res_o.runtime_tenth_min != '0));

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_res_o))
  // The block works on one request at a time, so it stalls right after taking one.
  `ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_IMPLIES(a_stale_zero, clk_i, rst_ni, stale_seen, stale_clean)
  `ASSERT_IMPLIES(a_runtime_flag, clk_i, rst_ni, out_valid_o, flag_ok)

endmodule

bind battery_monitor_runtime_estimator bmre_checker u_bmre_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);
